// ===== design/ilc_pkg.sv =====
`default_nettype none
package ilc_pkg;

   localparam int unsigned COEF_WIDTH_DEF = 64;
   localparam int unsigned IO_WIDTH       = 64;
   localparam int unsigned PT_WIDTH       = 30;
   localparam int unsigned DIFF_WIDTH     = PT_WIDTH + 1;
   localparam int unsigned PROD_WIDTH     = 2 * PT_WIDTH + 1;

   typedef enum logic [7:0] {
      ENG_IDLE  = 8'b0000_0001,
      ENG_ABS   = 8'b0000_0010,
      ENG_GINIT = 8'b0000_0100,
      ENG_GCD   = 8'b0000_1000,
      ENG_DIV   = 8'b0001_0000,
      ENG_FLIP  = 8'b0010_0000,
      ENG_NEG   = 8'b0100_0000,
      ENG_DONE  = 8'b1000_0000
   } ilc_eng_state_type;

endpackage
`default_nettype wire

// ===== design/ilc_pointform.sv =====
`default_nettype none
module ilc_pointform #(
   parameter int unsigned COEF_WIDTH = ilc_pkg::COEF_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] p_x,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] p_y,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] q_x,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] q_y,
   output logic                                done,
   output logic [COEF_WIDTH-1:0]               coef_a,
   output logic [COEF_WIDTH-1:0]               coef_b,
   output logic [COEF_WIDTH-1:0]               coef_c
);
   import ilc_pkg::*;

   logic [3:0]                   step_ff, step_in;
   logic signed [DIFF_WIDTH-1:0] da_ff, da_in, db_ff, db_in;
   logic signed [PT_WIDTH-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [DIFF_WIDTH-1:0] mul_x;
   logic signed [PT_WIDTH-1:0]   mul_y;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [COEF_WIDTH-1:0]        c_ff, c_in;
   logic signed [IO_WIDTH-1:0]   da_ext, db_ext, sum_ext, c_ext;

   // step 0 diffs ready, step 1 first product, step 2 second product, step 3 c ready
   assign step_in = {step_ff[2:0], go};

   assign da_in = go ? DIFF_WIDTH'(q_y) - DIFF_WIDTH'(p_y) : da_ff;
   assign db_in = go ? DIFF_WIDTH'(p_x) - DIFF_WIDTH'(q_x) : db_ff;
   assign px_in = go ? p_x : px_ff;
   assign py_in = go ? p_y : py_ff;

   // one multiplier, used for a*px then b*py
   assign mul_x   = step_ff[0] ? da_ff : db_ff;
   assign mul_y   = step_ff[0] ? px_ff : py_ff;
   assign prod_in = mul_x * mul_y;
   assign acc_in  = step_ff[1] ? prod_ff : acc_ff;

   assign sum_ext = IO_WIDTH'(acc_ff) + IO_WIDTH'(prod_ff);
   assign c_ext   = IO_WIDTH'(0) - sum_ext;
   assign c_in    = step_ff[2] ? c_ext[COEF_WIDTH-1:0] : c_ff;

   assign da_ext = IO_WIDTH'(da_ff);
   assign db_ext = IO_WIDTH'(db_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      da_ff   <= da_in;
      db_ff   <= db_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      c_ff    <= c_in;
   end

   assign done   = step_ff[3];
   assign coef_a = da_ext[COEF_WIDTH-1:0];
   assign coef_b = db_ext[COEF_WIDTH-1:0];
   assign coef_c = c_ff;

endmodule
`default_nettype wire

// ===== design/ilc_engine.sv =====
`default_nettype none
module ilc_engine #(
   parameter int unsigned COEF_WIDTH = ilc_pkg::COEF_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COEF_WIDTH-1:0] coef_a,
   input  logic [COEF_WIDTH-1:0] coef_b,
   input  logic [COEF_WIDTH-1:0] coef_c,
   output logic                  done,
   output logic [COEF_WIDTH-1:0] line_a,
   output logic [COEF_WIDTH-1:0] line_b,
   output logic [COEF_WIDTH-1:0] line_c,
   output logic                  is_valid
);
   import ilc_pkg::*;

   localparam int unsigned W  = COEF_WIDTH;
   localparam int unsigned KW = $clog2(COEF_WIDTH);

   ilc_eng_state_type state_ff, state_in;
   logic [1:0]    idx_ff, idx_in;
   logic [KW-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic          phase_ff, phase_in;
   logic [W-1:0]  val0_ff, val0_in, val1_ff, val1_in, val2_ff, val2_in;
   logic          sgn0_ff, sgn0_in, sgn1_ff, sgn1_in, sgn2_ff, sgn2_in;
   logic [W-1:0]  u_ff, u_in, v_ff, v_in, g_ff, g_in, rem_ff, rem_in;
   logic          flip_ff, flip_in, valid_ff, valid_in;

   // shared subtract / compare unit
   logic [W:0]    sub_x, sub_y;
   logic [W+1:0]  sub_d;
   logic          borrow;
   logic [W:0]    rem_sh;
   logic [W-1:0]  v0_new, gcd_res;
   logic          s0_new, rot, a0_zero;

   assign sub_d   = {1'b0, sub_x} - {1'b0, sub_y};
   assign borrow  = sub_d[W+1];
   assign rem_sh  = {rem_ff, val0_ff[W-1]};
   assign gcd_res = (u_ff | v_ff) << k_ff;
   assign a0_zero = (val0_ff == '0);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      flip_in  = flip_ff;
      valid_in = valid_ff;
      val1_in  = val1_ff;
      val2_in  = val2_ff;
      sgn1_in  = sgn1_ff;
      sgn2_in  = sgn2_ff;
      sub_x    = '0;
      sub_y    = '0;
      v0_new   = val0_ff;
      s0_new   = sgn0_ff;
      rot      = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               v0_new   = coef_a;
               val1_in  = coef_b;
               val2_in  = coef_c;
               idx_in   = '0;
               state_in = ENG_ABS;
            end
         end
         ENG_ABS: begin
            sub_y  = {1'b0, val0_ff};
            v0_new = val0_ff[W-1] ? sub_d[W-1:0] : val0_ff;
            s0_new = val0_ff[W-1];
            rot    = 1'b1;
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = ENG_GINIT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ENG_GINIT: begin
            // first pass gcd(|b|,|c|), second pass gcd(|a|, first result)
            u_in     = phase_ff ? val0_ff : val1_ff;
            v_in     = phase_ff ? g_ff : val2_ff;
            k_in     = '0;
            state_in = ENG_GCD;
         end
         ENG_GCD: begin
            sub_x = {1'b0, u_ff};
            sub_y = {1'b0, v_ff};
            priority if (u_ff == '0 || v_ff == '0) begin
               g_in = gcd_res;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  state_in = ENG_GINIT;
               end else if (gcd_res == '0) begin
                  state_in = ENG_FLIP;
               end else begin
                  cnt_in   = '0;
                  idx_in   = '0;
                  rem_in   = '0;
                  state_in = ENG_DIV;
               end
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (borrow) begin
               // keep u as the larger one
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               u_in = {1'b0, sub_d[W-1:1]};
            end
         end
         ENG_DIV: begin
            sub_x  = rem_sh;
            sub_y  = {1'b0, g_ff};
            rem_in = borrow ? rem_sh[W-1:0] : sub_d[W-1:0];
            v0_new = {val0_ff[W-2:0], ~borrow};
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(W - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               rot    = 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = ENG_FLIP;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ENG_FLIP: begin
            flip_in  = (sgn0_ff && !a0_zero) || (a0_zero && sgn1_ff && val1_ff != '0);
            valid_in = !a0_zero || val1_ff != '0;
            idx_in   = '0;
            state_in = ENG_NEG;
         end
         ENG_NEG: begin
            sub_y  = {1'b0, val0_ff};
            v0_new = (sgn0_ff ^ flip_ff) ? sub_d[W-1:0] : val0_ff;
            rot    = 1'b1;
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = ENG_DONE;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ENG_DONE: begin
            state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      // coefficients rotate so the active one always sits in slot 0
      if (rot) begin
         val0_in = val1_ff;
         val1_in = val2_ff;
         val2_in = v0_new;
         sgn0_in = sgn1_ff;
         sgn1_in = sgn2_ff;
         sgn2_in = s0_new;
      end else begin
         val0_in = v0_new;
         sgn0_in = s0_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      val0_ff  <= val0_in;
      val1_ff  <= val1_in;
      val2_ff  <= val2_in;
      sgn0_ff  <= sgn0_in;
      sgn1_ff  <= sgn1_in;
      sgn2_ff  <= sgn2_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      rem_ff   <= rem_in;
      flip_ff  <= flip_in;
      valid_ff <= valid_in;
   end

   assign done     = (state_ff == ENG_DONE);
   assign line_a   = val0_ff;
   assign line_b   = val1_ff;
   assign line_c   = val2_ff;
   assign is_valid = valid_ff;

endmodule
`default_nettype wire

// ===== design/integer_line_canonicalizer_unit.sv =====
`default_nettype none
// sequence: absolute values, two binary gcd passes, a bit-serial divide of each coefficient by the gcd,
// then the sign fix; point input first passes through the point former's shared multiplier
// the binary gcd loop and the bit-serial divider share one subtractor, one item at a time
// one item at a time; a new transfer is taken once the result is delivered
// reset: synchronous, active high, clears the sequencers, the busy flag and the response valid flag
module integer_line_canonicalizer_unit #(
   parameter int unsigned COEF_WIDTH = ilc_pkg::COEF_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic signed [ilc_pkg::IO_WIDTH-1:0] req_coef_a,
   input  logic signed [ilc_pkg::IO_WIDTH-1:0] req_coef_b,
   input  logic signed [ilc_pkg::IO_WIDTH-1:0] req_coef_c,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] req_p_x,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] req_p_y,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] req_q_x,
   input  logic signed [ilc_pkg::PT_WIDTH-1:0] req_q_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ilc_pkg::IO_WIDTH-1:0] rsp_line_a,
   output logic signed [ilc_pkg::IO_WIDTH-1:0] rsp_line_b,
   output logic signed [ilc_pkg::IO_WIDTH-1:0] rsp_line_c,
   output logic                                rsp_is_valid
);
   import ilc_pkg::*;

   localparam logic [IO_WIDTH-1:0] COEF_MIN =
      IO_WIDTH'($signed({1'b1, {(COEF_WIDTH - 1){1'b0}}}));

   logic busy_ff, busy_in, rsp_valid_ff, rsp_valid_in;
   logic signed [IO_WIDTH-1:0] line_a_ff, line_a_in, line_b_ff, line_b_in;
   logic signed [IO_WIDTH-1:0] line_c_ff, line_c_in;
   logic is_valid_ff, is_valid_in;
   logic req_xfer, rsp_xfer;

   logic                  pf_done;
   logic [COEF_WIDTH-1:0] pf_a, pf_b, pf_c;
   logic                  eng_start, eng_done, eng_is_valid;
   logic [COEF_WIDTH-1:0] eng_in_a, eng_in_b, eng_in_c;
   logic [COEF_WIDTH-1:0] eng_a, eng_b, eng_c;

   assign req_stall = busy_ff | rsp_valid_ff;
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;

   ilc_pointform #(
      .COEF_WIDTH(COEF_WIDTH)
   ) u_pointform (
      .clock  (clock),
      .reset  (reset),
      .go     (req_xfer & req_mode),
      .p_x    (req_p_x),
      .p_y    (req_p_y),
      .q_x    (req_q_x),
      .q_y    (req_q_y),
      .done   (pf_done),
      .coef_a (pf_a),
      .coef_b (pf_b),
      .coef_c (pf_c)
   );

   // raw coefficients go straight in on the transfer, points after the multiplier
   assign eng_start = (req_xfer & ~req_mode) | pf_done;
   assign eng_in_a  = pf_done ? pf_a : req_coef_a[COEF_WIDTH-1:0];
   assign eng_in_b  = pf_done ? pf_b : req_coef_b[COEF_WIDTH-1:0];
   assign eng_in_c  = pf_done ? pf_c : req_coef_c[COEF_WIDTH-1:0];

   ilc_engine #(
      .COEF_WIDTH(COEF_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (eng_start),
      .coef_a   (eng_in_a),
      .coef_b   (eng_in_b),
      .coef_c   (eng_in_c),
      .done     (eng_done),
      .line_a   (eng_a),
      .line_b   (eng_b),
      .line_c   (eng_c),
      .is_valid (eng_is_valid)
   );

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      line_a_in    = line_a_ff;
      line_b_in    = line_b_ff;
      line_c_in    = line_c_ff;
      is_valid_in  = is_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         busy_in = 1'b1;
      end
      if (eng_done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         line_a_in    = IO_WIDTH'($signed(eng_a));
         line_b_in    = IO_WIDTH'($signed(eng_b));
         line_c_in    = IO_WIDTH'($signed(eng_c));
         is_valid_in  = eng_is_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_a_ff   <= line_a_in;
      line_b_ff   <= line_b_in;
      line_c_ff   <= line_c_in;
      is_valid_ff <= is_valid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_line_a   = line_a_ff;
   assign rsp_line_b   = line_b_ff;
   assign rsp_line_c   = line_c_ff;
   assign rsp_is_valid = is_valid_ff;

   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      (eng_done || pf_done) |-> busy_ff)
      else $error("engine or point former finished with no item in flight");

   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_valid == (rsp_line_a != '0 || rsp_line_b != '0)))
      else $error("valid flag disagrees with coefficients");

   a_a_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_a[IO_WIDTH-1]) |-> (rsp_line_a == COEF_MIN))
      else $error("negative x coefficient after sign fix");

   a_b_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_a == '0 && rsp_line_b[IO_WIDTH-1]) |-> (rsp_line_b == COEF_MIN))
      else $error("negative y coefficient with zero x coefficient");

endmodule
`default_nettype wire
